// ===== hw/rtl/cyclic_alarm_timer_bank_macros.svh =====
// Assertion macros for the alarm timer bank.
`ifndef CYCLIC_ALARM_TIMER_BANK_MACROS_SVH
`define CYCLIC_ALARM_TIMER_BANK_MACROS_SVH

// same-cycle implication
`define CATB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CATB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/catb_pkg.sv =====
// Package: types, codes and constants of the alarm timer bank.
`timescale 1ns / 1ps
package catb_pkg;

   localparam int NUM_ALARMS_DEF = 16;
   localparam int TIME_BITS_DEF  = 32;

   localparam int OP_W       = 2;
   localparam int SLOT_W     = 4;
   localparam int ID_W       = 16;
   localparam int FIELD_MS_W = 32;
   localparam int STATUS_W   = 2;

   typedef enum logic [OP_W-1:0] {
      OP_TICK   = 2'd0,
      OP_SET    = 2'd1,
      OP_DELETE = 2'd2,
      OP_NONE   = 2'd3
   } catb_op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_NOT_USED = 2'd2
   } catb_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK,
      ST_TICK_END,
      ST_FLUSH,
      ST_SET,
      ST_DELETE
   } catb_state_type;

   typedef struct packed {
      logic rem_en;
      logic all_en;
   } catb_wr_ctl_type;

endpackage

// ===== hw/rtl/catb_slot_ram.sv =====
// Slot store: remaining time, period and alarm id per slot, registered read.
`timescale 1ns / 1ps
module catb_slot_ram #(
   parameter int NUM_ALARMS = catb_pkg::NUM_ALARMS_DEF,
   parameter int TIME_BITS  = catb_pkg::TIME_BITS_DEF,
   parameter int IDX_W      = $clog2(NUM_ALARMS)
) (
   input  logic                      clock,
   input  catb_pkg::catb_wr_ctl_type wr_ctl,
   input  logic [IDX_W-1:0]          wr_addr,
   input  logic [TIME_BITS-1:0]      wr_rem,
   input  logic [TIME_BITS-1:0]      wr_period,
   input  logic [catb_pkg::ID_W-1:0] wr_id,
   input  logic [IDX_W-1:0]          rd_addr,
   output logic [TIME_BITS-1:0]      rd_rem,
   output logic [TIME_BITS-1:0]      rd_period,
   output logic [catb_pkg::ID_W-1:0] rd_id
);
   import catb_pkg::*;

   logic [TIME_BITS-1:0] rem_mem    [NUM_ALARMS];
   logic [TIME_BITS-1:0] period_mem [NUM_ALARMS];
   logic [ID_W-1:0]      id_mem     [NUM_ALARMS];

   always_ff @(posedge clock) begin
      if (wr_ctl.rem_en || wr_ctl.all_en) begin
         rem_mem[wr_addr] <= wr_rem;
      end
      if (wr_ctl.all_en) begin
         period_mem[wr_addr] <= wr_period;
         id_mem[wr_addr]     <= wr_id;
      end
   end

   always_ff @(posedge clock) begin
      rd_rem    <= rem_mem[rd_addr];
      rd_period <= period_mem[rd_addr];
      rd_id     <= id_mem[rd_addr];
   end

endmodule

// ===== hw/rtl/catb_cmp_sub.sv =====
// Shared compare-subtract unit: remaining minus elapsed, and expiry test.
`timescale 1ns / 1ps
module catb_cmp_sub #(
   parameter int TIME_BITS = catb_pkg::TIME_BITS_DEF
) (
   input  logic [TIME_BITS-1:0] minuend,
   input  logic [TIME_BITS-1:0] subtrahend,
   output logic [TIME_BITS-1:0] diff,
   output logic                 at_or_below
);
   import catb_pkg::*;

   logic borrow;

   assign {borrow, diff} = {1'b0, minuend} - {1'b0, subtrahend};
   assign at_or_below    = borrow || (diff == '0);

endmodule

// ===== hw/rtl/cyclic_alarm_timer_bank.sv =====
// Top level: alarm slot bank with sequencer, slot store and compare-subtract unit.
`timescale 1ns / 1ps
`include "cyclic_alarm_timer_bank_macros.svh"
// Usage
//  Input: a word is taken on a rising edge with start high and busy low.
//   req_operation selects tick, set relative alarm or delete; operation 3
//   is dropped with no result.
//  Output: each result word sits on the rsp_ ports for one cycle with
//   rsp_strobe high; rsp_last marks the final word of an item. The receiver
//   cannot stall; there is no back-pressure input.
//  Sequencing (while busy):
//   tick   : one slot a cycle through the single
//            compare-subtract unit and the one read port of the slot store.
//   set    : the free-slot scan looks at one slot a cycle.
//   delete : the given slot is checked and freed if in use.
//   An item's final word comes in the same cycle that busy falls; a tick's
//   earlier notify words wait until the next slot fires.
//  Reset: synchronous, active high; all slots become free and disarmed.
//   Slot contents are written on set and are not cleared.
module cyclic_alarm_timer_bank #(
   parameter int NUM_ALARMS = catb_pkg::NUM_ALARMS_DEF,
   parameter int TIME_BITS  = catb_pkg::TIME_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [catb_pkg::OP_W-1:0]       req_operation,
   input  logic [catb_pkg::SLOT_W-1:0]     req_slot,
   input  logic [catb_pkg::ID_W-1:0]       req_alarm_id,
   input  logic [catb_pkg::FIELD_MS_W-1:0] req_start_ms,
   input  logic [catb_pkg::FIELD_MS_W-1:0] req_cycle_ms,
   input  logic [catb_pkg::FIELD_MS_W-1:0] req_elapsed_ms,
   output logic                            rsp_strobe,
   output logic                            rsp_notify,
   output logic [catb_pkg::ID_W-1:0]       rsp_fired_id,
   output logic [catb_pkg::SLOT_W-1:0]     rsp_slot_used,
   output logic [catb_pkg::STATUS_W-1:0]   rsp_status,
   output logic                            rsp_last
);
   import catb_pkg::*;

   localparam int IDX_W = $clog2(NUM_ALARMS);
   localparam int CMP_W = IDX_W + SLOT_W + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ALARMS - 1);

   catb_state_type state_ff, state_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  pipe_v_ff, pipe_v_in;
   logic [IDX_W-1:0]      pipe_idx_ff, pipe_idx_in;
   logic                  held_v_ff, held_v_in;
   logic [ID_W-1:0]       held_id_ff, held_id_in;
   logic [IDX_W-1:0]      held_slot_ff, held_slot_in;
   logic [NUM_ALARMS-1:0] armed_ff, armed_in;
   logic [NUM_ALARMS-1:0] alloc_ff, alloc_in;

   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic [TIME_BITS-1:0] start_ff, start_in;
   logic [TIME_BITS-1:0] cycle_ff, cycle_in;
   logic [TIME_BITS-1:0] elapsed_ff, elapsed_in;

   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic                 rsp_notify_ff, rsp_notify_in;
   logic [ID_W-1:0]      rsp_fired_id_ff, rsp_fired_id_in;
   logic [SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic                 rsp_last_ff, rsp_last_in;

   catb_wr_ctl_type      wr_ctl;
   logic [IDX_W-1:0]     wr_addr;
   logic [TIME_BITS-1:0] wr_rem;
   logic [TIME_BITS-1:0] rd_rem;
   logic [TIME_BITS-1:0] rd_period;
   logic [ID_W-1:0]      rd_id;
   logic [TIME_BITS-1:0] alu_diff;
   logic                 alu_le;

   logic                 accept;
   logic                 op_taken;
   logic                 slot_armed;
   logic                 fire;
   logic [IDX_W-1:0]     del_idx;
   logic                 del_ok;

   catb_slot_ram #(
      .NUM_ALARMS (NUM_ALARMS),
      .TIME_BITS  (TIME_BITS),
      .IDX_W      (IDX_W)
   ) u_slot_ram (
      .clock     (clock),
      .wr_ctl    (wr_ctl),
      .wr_addr   (wr_addr),
      .wr_rem    (wr_rem),
      .wr_period (cycle_ff),
      .wr_id     (id_ff),
      .rd_addr   (idx_ff),
      .rd_rem    (rd_rem),
      .rd_period (rd_period),
      .rd_id     (rd_id)
   );

   catb_cmp_sub #(
      .TIME_BITS (TIME_BITS)
   ) u_cmp_sub (
      .minuend     (rd_rem),
      .subtrahend  (elapsed_ff),
      .diff        (alu_diff),
      .at_or_below (alu_le)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign op_taken   = accept && (req_operation != OP_NONE);
   assign slot_armed = armed_ff[pipe_idx_ff];
   assign fire       = pipe_v_ff && slot_armed && alu_le;
   assign del_idx    = IDX_W'(slot_ff);
   assign del_ok     = (CMP_W'(slot_ff) < CMP_W'(NUM_ALARMS)) && alloc_ff[del_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pipe_v_ff     <= 1'b0;
         held_v_ff     <= 1'b0;
         armed_ff      <= '0;
         alloc_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pipe_v_ff     <= pipe_v_in;
         held_v_ff     <= held_v_in;
         armed_ff      <= armed_in;
         alloc_ff      <= alloc_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff          <= idx_in;
      pipe_idx_ff     <= pipe_idx_in;
      held_id_ff      <= held_id_in;
      held_slot_ff    <= held_slot_in;
      slot_ff         <= slot_in;
      id_ff           <= id_in;
      start_ff        <= start_in;
      cycle_ff        <= cycle_in;
      elapsed_ff      <= elapsed_in;
      rsp_notify_ff   <= rsp_notify_in;
      rsp_fired_id_ff <= rsp_fired_id_in;
      rsp_slot_ff     <= rsp_slot_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_last_ff     <= rsp_last_in;
   end

   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      pipe_v_in       = 1'b0;
      pipe_idx_in     = idx_ff;
      held_v_in       = held_v_ff;
      held_id_in      = held_id_ff;
      held_slot_in    = held_slot_ff;
      armed_in        = armed_ff;
      alloc_in        = alloc_ff;
      slot_in         = slot_ff;
      id_in           = id_ff;
      start_in        = start_ff;
      cycle_in        = cycle_ff;
      elapsed_in      = elapsed_ff;
      rsp_strobe_in   = 1'b0;
      rsp_notify_in   = 1'b0;
      rsp_fired_id_in = '0;
      rsp_slot_in     = '0;
      rsp_status_in   = STATUS_OK;
      rsp_last_in     = 1'b0;
      wr_ctl          = '0;
      wr_addr         = pipe_idx_ff;
      wr_rem          = alu_diff;

      // tick pipeline tail: slot read last cycle is judged here
      if (pipe_v_ff && slot_armed) begin
         wr_ctl.rem_en = 1'b1;
         if (alu_le) begin
            wr_rem = rd_period;
            if (rd_period == '0) begin
               armed_in[pipe_idx_ff] = 1'b0;
            end
         end
      end
      if (fire) begin
         if (held_v_ff) begin
            rsp_strobe_in   = 1'b1;
            rsp_notify_in   = 1'b1;
            rsp_fired_id_in = held_id_ff;
            rsp_slot_in     = SLOT_W'(held_slot_ff);
         end
         held_v_in    = 1'b1;
         held_id_in   = rd_id;
         held_slot_in = pipe_idx_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               slot_in    = req_slot;
               id_in      = req_alarm_id;
               start_in   = TIME_BITS'(req_start_ms);
               cycle_in   = TIME_BITS'(req_cycle_ms);
               elapsed_in = TIME_BITS'(req_elapsed_ms);
               idx_in     = '0;
               unique case (catb_op_type'(req_operation))
                  OP_TICK:   state_in = ST_TICK;
                  OP_SET:    state_in = ST_SET;
                  OP_DELETE: state_in = ST_DELETE;
                  OP_NONE:   state_in = ST_IDLE;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_TICK: begin
            pipe_v_in = 1'b1;
            idx_in    = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_TICK_END;
            end
         end
         ST_TICK_END: begin
            state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            rsp_strobe_in = 1'b1;
            rsp_last_in   = 1'b1;
            if (held_v_ff) begin
               rsp_notify_in   = 1'b1;
               rsp_fired_id_in = held_id_ff;
               rsp_slot_in     = SLOT_W'(held_slot_ff);
            end
            held_v_in = 1'b0;
            state_in  = ST_IDLE;
         end
         ST_SET: begin
            if (!alloc_ff[idx_ff]) begin
               wr_ctl.all_en    = 1'b1;
               wr_addr          = idx_ff;
               wr_rem           = start_ff;
               alloc_in[idx_ff] = 1'b1;
               armed_in[idx_ff] = 1'b1;
               rsp_strobe_in    = 1'b1;
               rsp_slot_in      = SLOT_W'(idx_ff);
               rsp_last_in      = 1'b1;
               state_in         = ST_IDLE;
            end else if (idx_ff == LAST_IDX) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = STATUS_FULL;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DELETE: begin
            rsp_strobe_in = 1'b1;
            rsp_slot_in   = slot_ff;
            rsp_last_in   = 1'b1;
            if (del_ok) begin
               alloc_in[del_idx] = 1'b0;
               armed_in[del_idx] = 1'b0;
            end else begin
               rsp_status_in = STATUS_NOT_USED;
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_notify    = rsp_notify_ff;
   assign rsp_fired_id  = rsp_fired_id_ff;
   assign rsp_slot_used = rsp_slot_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;

   `CATB_ASSERT_NOW(a_rsp_follows_work, clock, reset, rsp_strobe, $past(busy), "stray word")
   `CATB_ASSERT_NEXT(a_last_ends_run, clock, reset, rsp_strobe && rsp_last, !rsp_strobe, "late word")
   `CATB_ASSERT_NEXT(a_accept_goes_busy, clock, reset, op_taken, busy, "word not started")
   `CATB_ASSERT_NOW(a_idle_no_held, clock, reset, !busy, !held_v_ff, "held notify when idle")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the cyclic alarm timer bank: directed and random words.
`timescale 1ns / 1ps
module testbench;
   import catb_pkg::*;

   localparam int NUM_SLOTS    = NUM_ALARMS_DEF;
   localparam int RANDOM_WORDS = 280;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = NUM_SLOTS + 6;

   typedef struct packed {
      logic                notify;
      logic [ID_W-1:0]     fired_id;
      logic [SLOT_W-1:0]   slot_used;
      catb_status_type     status;
      logic                last;
   } alarm_result_type;

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  start          = 1'b0;
   logic [OP_W-1:0]       req_operation  = '0;
   logic [SLOT_W-1:0]     req_slot       = '0;
   logic [ID_W-1:0]       req_alarm_id   = '0;
   logic [FIELD_MS_W-1:0] req_start_ms   = '0;
   logic [FIELD_MS_W-1:0] req_cycle_ms   = '0;
   logic [FIELD_MS_W-1:0] req_elapsed_ms = '0;
   logic                  busy;
   logic                  rsp_strobe;
   logic                  rsp_notify;
   logic [ID_W-1:0]       rsp_fired_id;
   logic [SLOT_W-1:0]     rsp_slot_used;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  rsp_last;

   // predicted bank contents
   logic [FIELD_MS_W-1:0] slot_remaining [NUM_SLOTS];
   logic [FIELD_MS_W-1:0] slot_period    [NUM_SLOTS];
   logic [ID_W-1:0]       slot_id        [NUM_SLOTS];
   logic                  slot_armed     [NUM_SLOTS];
   logic                  slot_taken     [NUM_SLOTS];

   alarm_result_type alarm_results[$];

   int  mismatches   = 0;
   int  cycle_count  = 0;
   int  tick_words   = 0;
   int  set_words    = 0;
   int  delete_words = 0;
   int  idle_words   = 0;
   int  notify_seen  = 0;
   int  full_seen    = 0;
   bit  back_to_back = 1'b0;

   cyclic_alarm_timer_bank dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_operation  (req_operation),
      .req_slot       (req_slot),
      .req_alarm_id   (req_alarm_id),
      .req_start_ms   (req_start_ms),
      .req_cycle_ms   (req_cycle_ms),
      .req_elapsed_ms (req_elapsed_ms),
      .rsp_strobe     (rsp_strobe),
      .rsp_notify     (rsp_notify),
      .rsp_fired_id   (rsp_fired_id),
      .rsp_slot_used  (rsp_slot_used),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic clear_bank();
      for (int i = 0; i < NUM_SLOTS; i++) begin
         slot_remaining[i] = '0;
         slot_period[i]    = '0;
         slot_id[i]        = '0;
         slot_armed[i]     = 1'b0;
         slot_taken[i]     = 1'b0;
      end
   endtask

   task automatic queue_expected(alarm_result_type r);
      alarm_results = {alarm_results, r};
   endtask

   task automatic predict_alarm_results(catb_op_type op, logic [SLOT_W-1:0] slot,
                                        logic [ID_W-1:0] id,
                                        logic [FIELD_MS_W-1:0] first_ms,
                                        logic [FIELD_MS_W-1:0] period_ms,
                                        logic [FIELD_MS_W-1:0] elapsed_ms);
      alarm_result_type r;
      int               fired[$];
      int               free_slot;
      free_slot = -1;
      r = '{notify: 1'b0, fired_id: '0, slot_used: '0, status: STATUS_OK, last: 1'b1};
      case (op)
         OP_TICK: begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (slot_armed[i]) begin
                  if (slot_remaining[i] <= elapsed_ms) begin
                     if (slot_period[i] == '0) slot_armed[i] = 1'b0;
                     else slot_remaining[i] = slot_period[i];
                     fired = {fired, i};
                  end else begin
                     slot_remaining[i] = slot_remaining[i] - elapsed_ms;
                  end
               end
            end
            if (fired.size() == 0) begin
               queue_expected(r);
            end else begin
               foreach (fired[k]) begin
                  r.notify    = 1'b1;
                  r.fired_id  = slot_id[fired[k]];
                  r.slot_used = SLOT_W'(fired[k]);
                  r.last      = (k == fired.size() - 1);
                  queue_expected(r);
               end
            end
         end
         OP_SET: begin
            for (int i = NUM_SLOTS - 1; i >= 0; i--) if (!slot_taken[i]) free_slot = i;
            if (free_slot < 0) begin
               r.status = STATUS_FULL;
            end else begin
               slot_taken[free_slot]     = 1'b1;
               slot_armed[free_slot]     = 1'b1;
               slot_remaining[free_slot] = first_ms;
               slot_period[free_slot]    = period_ms;
               slot_id[free_slot]        = id;
               r.slot_used               = SLOT_W'(free_slot);
            end
            queue_expected(r);
         end
         OP_DELETE: begin
            r.slot_used = slot;
            if (slot_taken[slot]) begin
               slot_taken[slot] = 1'b0;
               slot_armed[slot] = 1'b0;
            end else begin
               r.status = STATUS_NOT_USED;
            end
            queue_expected(r);
         end
         default: ;
      endcase
   endtask

   task automatic send_word(catb_op_type op, logic [SLOT_W-1:0] slot, logic [ID_W-1:0] id,
                            logic [FIELD_MS_W-1:0] first_ms,
                            logic [FIELD_MS_W-1:0] period_ms,
                            logic [FIELD_MS_W-1:0] elapsed_ms);
      int gap;
      gap = back_to_back ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start          <= 1'b1;
      req_operation  <= op;
      req_slot       <= slot;
      req_alarm_id   <= id;
      req_start_ms   <= first_ms;
      req_cycle_ms   <= period_ms;
      req_elapsed_ms <= elapsed_ms;
      do @(posedge clock); while (busy !== 1'b0);
      predict_alarm_results(op, slot, id, first_ms, period_ms, elapsed_ms);
      case (op)
         OP_TICK:   tick_words++;
         OP_SET:    set_words++;
         OP_DELETE: delete_words++;
         default:   idle_words++;
      endcase
      @(negedge clock);
   endtask

   function automatic logic [FIELD_MS_W-1:0] pick_time(int span);
      case ($urandom_range(0, 9))
         0:       return $urandom;
         1:       return '0;
         default: return $urandom_range(0, span);
      endcase
   endfunction

   always @(posedge clock) begin
      alarm_result_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (alarm_results.size() == 0) begin
            $error("unexpected result word: slot_used %0d status %0d", rsp_slot_used,
                   rsp_status);
            mismatches++;
         end else begin
            want = alarm_results.pop_front();
            if (rsp_notify !== want.notify) begin
               $error("notify: expected %0d, got %0d", want.notify, rsp_notify);
               mismatches++;
            end
            if (rsp_fired_id !== want.fired_id) begin
               $error("fired_id: expected %0h, got %0h", want.fired_id, rsp_fired_id);
               mismatches++;
            end
            if (rsp_slot_used !== want.slot_used) begin
               $error("slot_used: expected %0d, got %0d", want.slot_used, rsp_slot_used);
               mismatches++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatches++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               mismatches++;
            end
            if (want.notify) notify_seen++;
            if (want.status == STATUS_FULL) full_seen++;
         end
      end
   end

   task automatic test_directed();
      send_word(OP_TICK, 4'd0, 16'd0, '0, '0, '0);
      send_word(OP_DELETE, 4'd0, 16'd0, '0, '0, '0);
      send_word(OP_DELETE, 4'd15, ID_W'($urandom), $urandom, $urandom, $urandom);
      send_word(OP_SET, 4'd0, 16'hFFFF, '0, '0, '0);
      send_word(OP_SET, 4'd15, 16'h0000, '1, '1, '0);
      send_word(OP_SET, 4'd0, 16'h1234, 32'd5, 32'd3, '1);
      send_word(OP_TICK, 4'd0, 16'd0, '0, '0, '0);
      send_word(OP_TICK, 4'd0, 16'd0, '0, '0, 32'd5);
      send_word(OP_TICK, 4'd0, 16'd0, '0, '0, 32'd2);
      send_word(OP_DELETE, 4'd0, 16'd0, '0, '0, '0);
      send_word(OP_TICK, 4'd0, 16'd0, '0, '0, '1);
      send_word(OP_NONE, SLOT_W'($urandom), ID_W'($urandom), $urandom, $urandom, $urandom);
      send_word(OP_SET, 4'd0, 16'hA5A5, 32'd1, 32'd0, '0);
      send_word(OP_DELETE, 4'd1, 16'd0, '0, '0, '0);
      send_word(OP_DELETE, 4'd1, 16'd0, '0, '0, '0);
      send_word(OP_TICK, 4'd0, 16'd0, '0, '0, 32'd1);
   endtask

   task automatic test_bank_full();
      int taken;
      taken = 0;
      foreach (slot_taken[i]) taken += slot_taken[i];
      back_to_back = 1'b1;
      repeat (NUM_SLOTS - taken)
         send_word(OP_SET, SLOT_W'($urandom), ID_W'($urandom), $urandom_range(0, 20),
                   $urandom_range(0, 20), $urandom);
      back_to_back = 1'b0;
      send_word(OP_SET, SLOT_W'($urandom), ID_W'($urandom), $urandom, $urandom, $urandom);
      send_word(OP_TICK, SLOT_W'($urandom), ID_W'($urandom), $urandom, $urandom, 32'd10);
      send_word(OP_DELETE, 4'd15, ID_W'($urandom), $urandom, $urandom, $urandom);
      send_word(OP_TICK, SLOT_W'($urandom), ID_W'($urandom), $urandom, $urandom, 32'd20);
   endtask

   task automatic test_random();
      int                sel;
      int                pick;
      logic [SLOT_W-1:0] target;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 20 == 0) back_to_back = ($urandom_range(0, 3) == 0);
         sel = $urandom_range(0, 99);
         if (sel < 45) begin
            send_word(OP_TICK, SLOT_W'($urandom), ID_W'($urandom), $urandom, $urandom,
                      pick_time(30));
         end else if (sel < 80) begin
            send_word(OP_SET, SLOT_W'($urandom), ID_W'($urandom), pick_time(60),
                      ($urandom_range(0, 3) == 0) ? '0 : pick_time(40), $urandom);
         end else if (sel < 97) begin
            target = SLOT_W'($urandom);
            if ($urandom_range(0, 3) != 0) begin
               pick = $urandom_range(0, NUM_SLOTS - 1);
               for (int k = 0; k < NUM_SLOTS; k++)
                  if (slot_taken[(pick + k) % NUM_SLOTS] && target == SLOT_W'($urandom))
                     target = SLOT_W'((pick + k) % NUM_SLOTS);
               for (int k = 0; k < NUM_SLOTS; k++)
                  if (slot_taken[(pick + k) % NUM_SLOTS]) target = SLOT_W'((pick + k) % NUM_SLOTS);
            end
            send_word(OP_DELETE, target, ID_W'($urandom), $urandom, $urandom, $urandom);
         end else begin
            send_word(OP_NONE, SLOT_W'($urandom), ID_W'($urandom), $urandom, $urandom,
                      $urandom);
         end
      end
      back_to_back = 1'b0;
   endtask

   initial begin
      clear_bank();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_bank_full();
      test_random();
      start <= 1'b0;
      while (alarm_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("tb: %0d ticks, %0d sets, %0d deletes, %0d ignored words sent",
               tick_words, set_words, delete_words, idle_words);
      $display("tb: %0d alarm notifications and %0d full-bank answers checked",
               notify_seen, full_seen);
      if (mismatches == 0 && alarm_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
